// ===== rtl/core/sjnq_pkg.sv =====
// ----------------------------------------------------------------------------
// sjnq_pkg
// Types and constants shared by the shortest-job-next / FIFO request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sjnq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned ID_W          = 32;
    localparam int unsigned LEN_W         = 32;
    localparam int unsigned ENTRY_W       = ID_W + LEN_W;
    localparam int unsigned CAP_W         = 5;
    localparam int unsigned OCC_W         = 5;
    localparam int unsigned CFG_IDX_W     = 1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_SJN_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_TAKEN    = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   request_id;
        logic [LEN_W-1:0]  job_length;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   out_request_id;
        logic [LEN_W-1:0]  out_job_length;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/sjnq_ram.sv =====
// ----------------------------------------------------------------------------
// sjnq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sjnq_ram import sjnq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [ENTRY_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/sjnq_seq.sv =====
// ----------------------------------------------------------------------------
// sjnq_seq
// Queue sequencer: ring pointers, compare-scan for the insert point and a
// pipelined one-slot shift, all through the single entry store port pair.
// ----------------------------------------------------------------------------
`default_nettype none

module sjnq_seq import sjnq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT,
    localparam int unsigned AW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1),
    localparam int unsigned LW   = (CW > CAP_W) ? CW : CAP_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_req             i_req,
    input  wire logic             i_sjn_mode,
    input  wire logic [CAP_W-1:0] i_capacity,
    input  wire logic             i_res_take,
    output logic                  o_idle,
    output logic                  o_res_valid,
    output t_rsp                  o_res
);

    t_seq_state         r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [ID_W-1:0]    r_id, n_id;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [AW-1:0]      r_raddr, n_raddr;
    logic [CW-1:0]      r_rk, n_rk;
    logic [CW-1:0]      r_ck, n_ck;
    logic               r_dv, n_dv;
    logic [AW-1:0]      r_src, n_src;
    logic [AW-1:0]      r_dst, n_dst;
    logic [CW-1:0]      r_left, n_left;
    logic               r_sdv, n_sdv;
    t_rsp               r_res, n_res;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [LW-1:0]      cap_ext;
    logic [LW-1:0]      limit;
    logic               full;
    logic [CW-1:0]      count_inc;
    logic [CW-1:0]      count_dec;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    sjnq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cap_ext   = LW'(i_capacity);
    assign limit     = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    assign full      = (LW'(r_count) >= limit);
    assign count_inc = r_count + CW'(1);
    assign count_dec = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_sdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_sdv   <= n_sdv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_len   <= n_len;
        r_raddr <= n_raddr;
        r_rk    <= n_rk;
        r_ck    <= n_ck;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_left  <= n_left;
        r_res   <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_id      = r_id;
        n_len     = r_len;
        n_raddr   = r_raddr;
        n_rk      = r_rk;
        n_ck      = r_ck;
        n_dv      = 1'b0;
        n_src     = r_src;
        n_dst     = r_dst;
        n_left    = r_left;
        n_sdv     = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_tail;
        ram_wdata = {r_id, r_len};
        ram_re    = 1'b0;
        ram_raddr = r_raddr;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_id  = i_req.request_id;
                    n_len = i_req.job_length;
                    n_res.out_request_id = '0;
                    n_res.out_job_length = '0;
                    n_res.occupancy      = OCC_W'(r_count);
                    if (i_req.kind == KIND_TAKE) begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_head;
                            n_state   = S_TAKE;
                        end
                    end else if (full) begin
                        n_res.status         = ST_REJECTED;
                        n_res.out_request_id = i_req.request_id;
                        n_res.out_job_length = i_req.job_length;
                        n_state              = S_DONE;
                    end else if (!i_sjn_mode || (r_count == '0)) begin
                        ram_we          = 1'b1;
                        ram_waddr       = r_tail;
                        ram_wdata       = {i_req.request_id, i_req.job_length};
                        n_tail          = ring_inc(r_tail);
                        n_count         = count_inc;
                        n_res.status    = ST_ACCEPTED;
                        n_res.occupancy = OCC_W'(count_inc);
                        n_state         = S_DONE;
                    end else begin
                        n_raddr = r_head;
                        n_rk    = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_TAKE: begin
                n_res.status         = ST_TAKEN;
                n_res.out_request_id = ram_rdata[ENTRY_W-1:LEN_W];
                n_res.out_job_length = ram_rdata[LEN_W-1:0];
                n_res.occupancy      = OCC_W'(count_dec);
                n_head               = ring_inc(r_head);
                n_count              = count_dec;
                n_state              = S_DONE;
            end
            S_SCAN: begin
                // read of slot k overlaps the compare of slot k-1
                if (r_rk < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_raddr;
                    n_raddr   = ring_inc(r_raddr);
                    n_rk      = r_rk + CW'(1);
                    n_dv      = 1'b1;
                end
                n_ck = r_rk;
                if (r_dv) begin
                    if (r_len < ram_rdata[LEN_W-1:0]) begin
                        n_left  = r_count - r_ck;
                        n_src   = ring_dec(r_tail);
                        n_dst   = r_tail;
                        n_dv    = 1'b0;
                        n_state = S_SHIFT;
                    end else if (r_ck == count_dec) begin
                        n_left  = '0;
                        n_src   = ring_dec(r_tail);
                        n_dst   = r_tail;
                        n_dv    = 1'b0;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // read slot k-1 while writing the previous read into its new slot
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_src;
                    n_src     = ring_dec(r_src);
                    n_left    = r_left - CW'(1);
                    n_sdv     = 1'b1;
                end
                if (r_sdv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dst;
                    ram_wdata = ram_rdata;
                    n_dst     = ring_dec(r_dst);
                end else if (r_left == '0) begin
                    ram_we               = 1'b1;
                    ram_waddr            = r_dst;
                    ram_wdata            = {r_id, r_len};
                    n_tail               = ring_inc(r_tail);
                    n_count              = count_inc;
                    n_res.status         = ST_ACCEPTED;
                    n_res.out_request_id = '0;
                    n_res.out_job_length = '0;
                    n_res.occupancy      = OCC_W'(count_inc);
                    n_state              = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/sjn_or_fifo_request_queue.sv =====
// ----------------------------------------------------------------------------
// sjn_or_fifo_request_queue
// Bounded request queue, first-in-first-out or shortest-job-next order.
// ----------------------------------------------------------------------------
// One request beat at a time; every beat gives one response beat. A reject,
// a take on empty and an add in FIFO mode or into an empty queue are
// answered from the idle state; a take first reads the head slot. An SJN add
// into a non-empty queue runs a pipelined compare scan from the head for the
// insert point, then a one-slot-per-cycle shift from the tail that moves
// every entry at or behind that point (nothing moves when it goes last),
// both through the single read and single write port of the entry store.
// The request side is ready again once the response loads into the output
// register, provided that register is free or its beat is being taken.
// The store needs no clearing after reset. A finished response waits in the
// output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sjn_or_fifo_request_queue import sjnq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire t_req                 i_req,
    output logic                      o_rsp_valid,
    input  wire logic                 i_rsp_ready,
    output t_rsp                      o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CAP_W-1:0]     i_cfg_wdata
);

    logic             r_sjn_mode;
    logic [CAP_W-1:0] r_capacity;
    logic             r_ovalid;
    t_rsp             r_out;

    logic             seq_idle;
    logic             seq_res_valid;
    t_rsp             seq_res;
    logic             start;
    logic             res_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sjn_mode <= 1'b0;
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SJN_MODE: r_sjn_mode <= i_cfg_wdata[0];
                REG_CAPACITY: r_capacity <= i_cfg_wdata;
                default:      r_sjn_mode <= r_sjn_mode;
            endcase
        end
    end

    assign o_req_ready = seq_idle;
    assign start       = i_req_valid && seq_idle;
    assign res_take    = seq_res_valid && (!r_ovalid || i_rsp_ready);

    sjnq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_sjn_mode  (r_sjn_mode),
        .i_capacity  (r_capacity),
        .i_res_take  (res_take),
        .o_idle      (seq_idle),
        .o_res_valid (seq_res_valid),
        .o_res       (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= seq_res;
        end
    end

    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_EMPTY)) |-> (o_rsp.occupancy == '0))
        else $error("empty response with nonzero occupancy");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && ((o_rsp.status == ST_ACCEPTED) || (o_rsp.status == ST_EMPTY)))
        |-> ((o_rsp.out_request_id == '0) && (o_rsp.out_job_length == '0)))
        else $error("accepted or empty response carries payload");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (int'(o_rsp.occupancy) <= DEPTH))
        else $error("occupancy beyond depth");

    a_accept_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == ST_ACCEPTED)) |-> (o_rsp.occupancy != '0))
        else $error("accepted beat leaves queue empty");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sjn_or_fifo_request_queue_test.sv =====
// ----------------------------------------------------------------------------
// sjn_or_fifo_request_queue_test
// Self-checking bench for the FIFO / shortest-job-next request queue.
// ----------------------------------------------------------------------------
// A queue of pending request beats feeds a clocked driver that sends them,
// in some phases in bursts with random gaps. A clocked monitor stalls the
// response side on a per-phase pattern and checks each response beat against
// a queue of predicted responses. The prediction keeps an ordered list of
// held jobs and the current mode and capacity. A short directed part is
// followed by random phases. Between phases every beat is answered and the
// registers rewritten, sweeping modes and capacities from zero past depth.
// ----------------------------------------------------------------------------
module sjn_or_fifo_request_queue_test;
    import sjnq_pkg::*;

    localparam int unsigned QDEPTH     = DEPTH_DEFAULT;
    localparam int          DRAIN_WAIT = 2 * QDEPTH + 8;
    localparam int          WATCHDOG   = 4000;
    localparam int          PHASES     = 20;
    localparam int          PHASE_LEN  = 100;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
    } t_job;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 req_valid   = 1'b0;
    t_req                 req_beat    = '0;
    logic                 rsp_ready   = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx     = '0;
    logic [CAP_W-1:0]     cfg_wdata   = '0;
    logic                 o_req_ready;
    logic                 o_rsp_valid;
    t_rsp                 o_rsp;

    t_req        pending_reqs[$];
    t_rsp        due_rsps[$];
    t_job        queued_jobs[$];
    logic        sjn_now    = 1'b0;
    logic [4:0]  cap_now    = CAPACITY_RESET;
    logic        bursty     = 1'b0;
    int          stall_mode = 0;
    int          errors     = 0;
    int          burst_left = 0;
    int          gap_left   = 0;
    int          quiet      = 0;
    int unsigned cyc        = 0;

    sjn_or_fifo_request_queue #(.DEPTH(QDEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req_beat),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_rsp serve_request(input t_req r);
        t_rsp        rsp;
        t_job        job;
        int unsigned limit;
        int          pos;
        rsp   = '0;
        limit = (cap_now > QDEPTH) ? QDEPTH : cap_now;
        if (r.kind == KIND_ADD) begin
            if (queued_jobs.size() >= limit) begin
                rsp.status         = ST_REJECTED;
                rsp.out_request_id = r.request_id;
                rsp.out_job_length = r.job_length;
            end else begin
                pos = queued_jobs.size();
                if (sjn_now) begin
                    for (int k = 0; k < queued_jobs.size(); k++) begin
                        if (r.job_length < queued_jobs[k].len) begin
                            pos = k;
                            break;
                        end
                    end
                end
                job.id  = r.request_id;
                job.len = r.job_length;
                queued_jobs.insert(pos, job);
                rsp.status = ST_ACCEPTED;
            end
        end else if (queued_jobs.size() == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            job                = queued_jobs.pop_front();
            rsp.status         = ST_TAKEN;
            rsp.out_request_id = job.id;
            rsp.out_job_length = job.len;
        end
        rsp.occupancy = OCC_W'(queued_jobs.size());
        return rsp;
    endfunction

    // request driver: bursts of beats with random gaps when bursty is set
    always @(posedge i_clk) begin : drive
        logic nxt_valid;
        t_req nxt_req;
        nxt_valid = req_valid;
        nxt_req   = req_beat;
        if (i_rst_n) begin
            if (req_valid && o_req_ready) begin
                due_rsps.push_back(serve_request(req_beat));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    nxt_req   = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    if (bursty) begin
                        if (burst_left <= 1) begin
                            burst_left = $urandom_range(1, 16);
                            gap_left   = $urandom_range(1, 10);
                        end else begin
                            burst_left--;
                        end
                    end
                end
            end
        end
        req_valid <= nxt_valid;
        req_beat  <= nxt_req;
    end

    // response monitor and receiver stalls
    always @(posedge i_clk) begin : watch
        t_rsp want;
        cyc++;
        if (i_rst_n && o_rsp_valid && rsp_ready) begin
            if (due_rsps.size() == 0) begin
                if (errors < 10)
                    $display("unexpected response: st=%0d id=%h len=%h occ=%0d",
                             o_rsp.status, o_rsp.out_request_id,
                             o_rsp.out_job_length, o_rsp.occupancy);
                errors++;
            end else begin
                want = due_rsps.pop_front();
                if (o_rsp.status !== want.status
                        || o_rsp.out_request_id !== want.out_request_id
                        || o_rsp.out_job_length !== want.out_job_length
                        || o_rsp.occupancy !== want.occupancy) begin
                    if (errors < 10)
                        $display("mismatch: exp st=%0d id=%h len=%h occ=%0d,",
                                 want.status, want.out_request_id,
                                 want.out_job_length, want.occupancy,
                                 " got st=%0d id=%h len=%h occ=%0d",
                                 o_rsp.status, o_rsp.out_request_id,
                                 o_rsp.out_job_length, o_rsp.occupancy);
                    errors++;
                end
            end
        end
        case (stall_mode)
            0: begin
                rsp_ready <= 1'b1;
            end
            1: begin
                rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                rsp_ready <= ((cyc % 11) < 6);
            end
            default: begin
                rsp_ready <= ($urandom_range(0, 9) < 3);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && o_req_ready) || (o_rsp_valid && rsp_ready) || cfg_we) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        if (idx == REG_SJN_MODE)
            sjn_now = data[0];
        else
            cap_now = data;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_add(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len);
        t_req r;
        r.kind       = KIND_ADD;
        r.request_id = id;
        r.job_length = len;
        pending_reqs.push_back(r);
    endtask

    task automatic push_take();
        t_req r;
        r.kind       = KIND_TAKE;
        r.request_id = $urandom;
        r.job_length = $urandom;
        pending_reqs.push_back(r);
    endtask

    // hold off until every beat is sent and answered
    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || due_rsps.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic random_phase(input int n);
        int                 add_pct;
        logic [LEN_W-1:0]   len;
        add_pct = $urandom_range(25, 75);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < add_pct) begin
                case ($urandom_range(0, 9))
                    6, 7:    len = $urandom;
                    8:       len = '0;
                    9:       len = '1;
                    default: len = LEN_W'($urandom_range(0, 7));
                endcase
                push_add($urandom, len);
            end else begin
                push_take();
            end
        end
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0] cap;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // FIFO at reset settings, take on empty, field extremes
        push_take();
        push_add('0, '0);
        push_add('1, '1);
        push_add(32'h0000_0012, 32'h0000_0007);
        repeat (4) push_take();
        drain();

        // SJN ordering with ties, an empty and a longest job
        write_reg(REG_SJN_MODE, 5'b10101);
        end_writes();
        push_add(32'd1, 32'd5);
        push_add(32'd2, 32'd3);
        push_add(32'd3, 32'd5);
        push_add(32'd4, 32'd0);
        push_add(32'd5, 32'hFFFF_FFFF);
        push_add(32'd6, 32'd3);
        drain();

        // capacity dropped below the held count
        write_reg(REG_CAPACITY, 5'd2);
        end_writes();
        push_add(32'd7, 32'd1);
        repeat (5) push_take();
        push_add(32'd8, 32'd2);
        push_add(32'd9, 32'd1);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       cap = 5'd31;
                1:       cap = 5'd0;
                2:       cap = 5'd1;
                3:       cap = 5'd16;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       cap = 5'd0;
                        1:       cap = 5'd1;
                        2:       cap = CAP_W'($urandom_range(17, 31));
                        3:       cap = 5'd16;
                        default: cap = CAP_W'($urandom_range(2, 15));
                    endcase
                end
            endcase
            if (p < 4 || $urandom_range(0, 3) != 0)
                write_reg(REG_SJN_MODE, (p < 4) ? {4'($urandom), 1'(p % 2)} : 5'($urandom));
            write_reg(REG_CAPACITY, cap);
            end_writes();
            bursty     = (p % 4 != 1) && ($urandom_range(0, 4) != 0);
            stall_mode = (p % 4 == 1) ? 0 : $urandom_range(0, 3);
            random_phase(PHASE_LEN);
            drain();
        end

        if (errors == 0 && due_rsps.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sjnq_pkg.sv
rtl/core/sjnq_ram.sv
rtl/core/sjnq_seq.sv
rtl/core/sjn_or_fifo_request_queue.sv
tb/sv/sjn_or_fifo_request_queue_test.sv
